// ----- design/salc_pkg.sv -----
// Shared types and constants for the set-associative LRU cache tag block.
// No dependencies; used by set_assoc_lru_cache_tags.sv.
`default_nettype none

package salc_pkg;

  // Default geometry, handed to the top level as parameter defaults
  localparam int WAYS_DEF        = 8;
  localparam int SET_BITS_DEF    = 6;
  localparam int OFFSET_BITS_DEF = 6;
  localparam int ADDR_BITS_DEF   = 48;

  // Fixed port field widths
  localparam int LINE_ADDR_W = 48;
  localparam int STAMP_W     = 32;

  localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

  // Operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ALLOC  = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic [LINE_ADDR_W-1:0] line_address;
    logic                   write_access;
    logic                   allocate_dirty;
    logic [STAMP_W-1:0]     use_stamp;
  } in_item_t;

  typedef struct packed {
    logic                   hit;
    logic                   victim_dirty;
    logic [LINE_ADDR_W-1:0] victim_addr;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/salc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module salc_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/set_assoc_lru_cache_tags.sv -----
// Top level: tag store of a set-associative write-back cache with stamp LRU.
// Depends on salc_pkg and salc_ram.
//
//   Channel | Ports                          | Content
//   --------+--------------------------------+-------------------------------------
//   in      | in_valid, in_ready, in_item    | lookup or allocate request
//   out     | out_valid, out_ready, out_item | hit, dirty victim and its line address
//
// The ways of the set are read one per cycle from a single tag RAM port and
// checked by one compare unit, then the chosen way is written back (for a
// lookup only on a hit). After reset a clearing pass writes every RAM entry
// with in_ready low.
// A finished result waits in the output register; a new request is taken
// meanwhile, and only the final write stalls while that result is not taken.
`default_nettype none

module set_assoc_lru_cache_tags #(
  parameter int WAYS        = salc_pkg::WAYS_DEF,
  parameter int SET_BITS    = salc_pkg::SET_BITS_DEF,
  parameter int OFFSET_BITS = salc_pkg::OFFSET_BITS_DEF,
  parameter int ADDR_BITS   = salc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire salc_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output salc_pkg::out_item_t      out_item
);

  localparam int WayW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AddrW   = SET_BITS + WayW;
  localparam int Depth   = 1 << AddrW;
  localparam int TagW    = ADDR_BITS - OFFSET_BITS - SET_BITS;
  localparam int StampW  = salc_pkg::STAMP_W;
  localparam int LineW   = salc_pkg::LINE_ADDR_W;
  localparam int EntryW  = 2 + TagW + StampW;
  localparam int AddrExtW = (ADDR_BITS > LineW) ? ADDR_BITS : LineW;
  localparam logic [WayW-1:0] LastWay = WayW'(WAYS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  state_t state_r, state_nxt;

  // Latched request
  logic                op_r, op_nxt;
  logic [SET_BITS-1:0] set_r, set_nxt;
  logic [TagW-1:0]     tag_r, tag_nxt;
  logic                wr_r, wr_nxt;
  logic                adirty_r, adirty_nxt;
  logic [StampW-1:0]   stamp_r, stamp_nxt;

  // Scan sequencer
  logic [WayW-1:0]     rd_way_r, rd_way_nxt;
  logic                issued_r, issued_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [WayW-1:0]     chk_way_r, chk_way_nxt;
  logic [AddrW-1:0]    clr_r, clr_nxt;

  // Selected way
  logic                found_r, found_nxt;
  logic                stop_r, stop_nxt;
  logic [WayW-1:0]     sel_way_r, sel_way_nxt;
  logic                sel_valid_r, sel_valid_nxt;
  logic                sel_dirty_r, sel_dirty_nxt;
  logic [TagW-1:0]     sel_tag_r, sel_tag_nxt;
  logic [StampW-1:0]   oldest_r, oldest_nxt;

  logic                out_vld_r, out_vld_nxt;
  salc_pkg::out_item_t out_r, out_nxt;

  // RAM ports
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  logic              rd_valid;
  logic              rd_dirty;
  logic [TagW-1:0]   rd_tag;
  logic [StampW-1:0] rd_stamp;
  logic [StampW-1:0] cur_oldest;
  logic              tag_eq;
  logic              stamp_lt;

  logic [AddrExtW-1:0]  in_addr_ext;
  logic [ADDR_BITS-1:0] in_addr;
  logic [ADDR_BITS-1:0] vict_addr;
  logic [AddrExtW-1:0]  vict_addr_ext;
  logic                 new_dirty;
  logic                 evict;

  salc_ram #(
    .W     (EntryW),
    .DEPTH (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry layout: valid, dirty, tag, stamp
  assign rd_valid = ram_rdata[EntryW-1];
  assign rd_dirty = ram_rdata[EntryW-2];
  assign rd_tag   = ram_rdata[StampW +: TagW];
  assign rd_stamp = ram_rdata[StampW-1:0];

  // Address split of the incoming request
  assign in_addr_ext = AddrExtW'(in_item.line_address);
  assign in_addr     = in_addr_ext[ADDR_BITS-1:0];

  // Shared compare unit
  assign cur_oldest = (chk_way_r == '0) ? salc_pkg::STAMP_MAX : oldest_r;
  assign tag_eq     = (rd_tag == tag_r);
  assign stamp_lt   = (rd_stamp < cur_oldest);

  // Result fields
  assign new_dirty     = (op_r == salc_pkg::OP_ALLOC) ? adirty_r : (sel_dirty_r | wr_r);
  assign evict         = (op_r == salc_pkg::OP_ALLOC) && sel_valid_r && sel_dirty_r;
  assign vict_addr     = {sel_tag_r, set_r, {OFFSET_BITS{1'b0}}};
  assign vict_addr_ext = AddrExtW'(vict_addr);

  assign ram_raddr = {set_r, rd_way_r};

  // RAM write port: clearing pass or write-back of the chosen way
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {set_r, sel_way_r};
    ram_wdata = {1'b1, new_dirty, tag_r, stamp_r};
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == S_WRITE && (!out_vld_r || out_ready)) begin
      ram_we = (op_r == salc_pkg::OP_ALLOC) || found_r;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    set_nxt       = set_r;
    tag_nxt       = tag_r;
    wr_nxt        = wr_r;
    adirty_nxt    = adirty_r;
    stamp_nxt     = stamp_r;
    rd_way_nxt    = rd_way_r;
    issued_nxt    = issued_r;
    chk_vld_nxt   = 1'b0;
    chk_way_nxt   = rd_way_r;
    clr_nxt       = clr_r;
    found_nxt     = found_r;
    stop_nxt      = stop_r;
    sel_way_nxt   = sel_way_r;
    sel_valid_nxt = sel_valid_r;
    sel_dirty_nxt = sel_dirty_r;
    sel_tag_nxt   = sel_tag_r;
    oldest_nxt    = oldest_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    out_nxt       = out_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AddrW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_item.opcode;
          set_nxt     = in_addr[OFFSET_BITS +: SET_BITS];
          tag_nxt     = in_addr[ADDR_BITS-1 -: TagW];
          wr_nxt      = in_item.write_access;
          adirty_nxt  = in_item.allocate_dirty;
          stamp_nxt   = in_item.use_stamp;
          rd_way_nxt  = '0;
          issued_nxt  = 1'b0;
          found_nxt   = 1'b0;
          stop_nxt    = 1'b0;
          sel_way_nxt = '0;
          state_nxt   = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one way read per cycle
        if (!issued_r) begin
          chk_vld_nxt = 1'b1;
          if (rd_way_r == LastWay) begin
            issued_nxt = 1'b1;
          end else begin
            rd_way_nxt = rd_way_r + WayW'(1);
          end
        end
        // Check the way read in the previous cycle
        if (chk_vld_r) begin
          if (op_r == salc_pkg::OP_LOOKUP) begin
            if (!found_r && rd_valid && tag_eq) begin
              found_nxt     = 1'b1;
              sel_way_nxt   = chk_way_r;
              sel_dirty_nxt = rd_dirty;
            end
          end else if (!stop_r) begin
            if (chk_way_r == '0 || !rd_valid || stamp_lt) begin
              sel_way_nxt   = chk_way_r;
              sel_valid_nxt = rd_valid;
              sel_dirty_nxt = rd_dirty;
              sel_tag_nxt   = rd_tag;
              oldest_nxt    = (chk_way_r == '0 && !stamp_lt) ? cur_oldest : rd_stamp;
              stop_nxt      = !rd_valid;
            end
          end
          if (chk_way_r == LastWay) begin
            state_nxt = S_WRITE;
          end
        end
      end

      S_WRITE: begin
        // Hold while the previous result is still waiting
        if (!out_vld_r || out_ready) begin
          out_vld_nxt          = 1'b1;
          out_nxt.hit          = (op_r == salc_pkg::OP_LOOKUP) && found_r;
          out_nxt.victim_dirty = evict;
          out_nxt.victim_addr  = evict ? vict_addr_ext[LineW-1:0] : '0;
          state_nxt            = S_IDLE;
        end
      end

      default: state_nxt = S_CLEAR;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      issued_r  <= 1'b0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      issued_r  <= issued_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    op_r        <= op_nxt;
    set_r       <= set_nxt;
    tag_r       <= tag_nxt;
    wr_r        <= wr_nxt;
    adirty_r    <= adirty_nxt;
    stamp_r     <= stamp_nxt;
    rd_way_r    <= rd_way_nxt;
    chk_way_r   <= chk_way_nxt;
    found_r     <= found_nxt;
    stop_r      <= stop_nxt;
    sel_way_r   <= sel_way_nxt;
    sel_valid_r <= sel_valid_nxt;
    sel_dirty_r <= sel_dirty_nxt;
    sel_tag_r   <= sel_tag_nxt;
    oldest_r    <= oldest_nxt;
    out_r       <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  // A result is either a lookup hit or an eviction, never both
  a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.hit && out_item.victim_dirty))
    else $error("hit and eviction reported together");

  // Victim address is line aligned and zero without an eviction
  a_evict_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.victim_addr[OFFSET_BITS-1:0] == '0) &&
                  (out_item.victim_dirty || out_item.victim_addr == '0))
    else $error("bad evicted address");

  // Block is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

endmodule

`default_nettype wire
